// ===== design/running_error_norm_tracker_assert.svh =====
// Assertion macros for the running error norm tracker
`ifndef RUNNING_ERROR_NORM_TRACKER_ASSERT_SVH
`define RUNNING_ERROR_NORM_TRACKER_ASSERT_SVH

// Same-cycle implication under reset
`define RENT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset
`define RENT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rent_pkg.sv =====
// Shared constants, codes and types of the running error norm tracker
`default_nettype none
package rent_pkg;
    localparam int MAX_ELEMENTS = 1024;
    localparam int ERROR_BITS   = 16;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int SUM_W        = 42;
    localparam int AGG_W        = 32;
    localparam int UPD_W        = 17;
    localparam int UPD_MAX      = 65535;
    localparam int TERM_W       = 2 * ERROR_BITS;
    localparam int DIV_STEPS    = SUM_W;
    localparam int DCNT_W       = $clog2(DIV_STEPS + 1);
    localparam int PADDR_W      = 5;
    localparam int ELEM_W       = 11;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_REM = 2'd1;
    localparam logic [1:0] FUNC_UPD = 2'd2;

    localparam logic [1:0] TM_NEVER = 2'd0;
    localparam logic [1:0] TM_COUNT = 2'd1;
    localparam logic [1:0] TM_LEVEL = 2'd2;

    localparam logic [1:0] NK_MAX  = 2'd0;
    localparam logic [1:0] NK_MEAN = 2'd1;
    localparam logic [1:0] NK_SQR  = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_ABSENT = 2'd2;

    localparam logic [2:0] REG_TERM_MODE    = 3'd0;
    localparam logic [2:0] REG_NORM_KIND    = 3'd1;
    localparam logic [2:0] REG_DIRECTION    = 3'd2;
    localparam logic [2:0] REG_UPDATE_LIMIT = 3'd3;
    localparam logic [2:0] REG_ERROR_LEVEL  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD,
        ST_FIND,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_RECOMP,
        ST_DIV,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic add_commit;
        logic scan_start;
        logic scan_step;
        logic move_rd;
        logic move_wr;
        logic div_start;
        logic div_step;
        logic agg_zero;
        logic agg_div;
        logic agg_max;
        logic upd_inc;
        logic st_full;
        logic st_absent;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_add;
        logic is_rem;
        logic is_upd;
        logic full;
        logic cnt_zero;
        logic mean_norm;
        logic scan_done;
        logic hit;
        logic div_done;
        logic out_free;
    } t_stat;
endpackage
`default_nettype wire

// ===== design/rent_ram.sv =====
// Generic simple dual-port RAM with registered read
`default_nettype none
module rent_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/rent_ctrl.sv =====
// Controller state machine of the running error norm tracker
`default_nettype none
module rent_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire rent_pkg::t_stat i_stat,
    output rent_pkg::t_cmd      o_cmd
);
    import rent_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_stat.is_add) begin
                    if (i_stat.full) begin
                        o_cmd.st_full = 1'b1;
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_ADD;
                    end
                end else if (i_stat.is_rem) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = ST_FIND;
                end else if (i_stat.is_upd) begin
                    o_cmd.upd_inc = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_ADD: begin
                o_cmd.add_commit = 1'b1;
                n_state = ST_RECOMP;
            end
            ST_FIND: begin
                if (i_stat.hit) begin
                    n_state = ST_MOVE_RD;
                end else if (i_stat.scan_done) begin
                    o_cmd.st_absent = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_MOVE_RD: begin
                o_cmd.move_rd = 1'b1;
                n_state = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                o_cmd.move_wr = 1'b1;
                n_state = ST_RECOMP;
            end
            ST_RECOMP: begin
                if (i_stat.cnt_zero) begin
                    o_cmd.agg_zero = 1'b1;
                    n_state = ST_FINISH;
                end else if (i_stat.mean_norm) begin
                    o_cmd.div_start = 1'b1;
                    n_state = ST_DIV;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.agg_div = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    o_cmd.agg_max = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== design/rent_dp.sv =====
// Datapath of the running error norm tracker: table, sums, divider, config, result
`default_nettype none
module rent_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire rent_pkg::t_cmd                      i_cmd,
    output rent_pkg::t_stat                          o_stat,
    input  wire logic [1:0]                          i_func,
    input  wire logic [rent_pkg::ERROR_BITS-1:0]     i_error_value,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [rent_pkg::AGG_W-1:0]               o_total_error,
    output logic [rent_pkg::ELEM_W-1:0]              o_element_count,
    output logic signed [rent_pkg::UPD_W-1:0]        o_updates_done,
    output logic                                     o_terminate,
    output logic [1:0]                               o_status,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rent_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata
);
    import rent_pkg::*;

    logic [1:0]              r_term_mode, r_norm_kind;
    logic                    r_direction;
    logic [15:0]             r_update_limit;
    logic [31:0]             r_error_level;

    logic [1:0]              r_func;
    logic [ERROR_BITS-1:0]   r_val;
    logic [TERM_W-1:0]       r_term;
    logic [CNT_W-1:0]        r_count;
    logic [SUM_W-1:0]        r_sum;
    logic [AGG_W-1:0]        r_agg;
    logic signed [UPD_W-1:0] r_upd;
    logic [1:0]              r_status;
    logic [CNT_W-1:0]        r_idx;
    logic                    r_pend;
    logic [ADDR_W-1:0]       r_pidx, r_hit_idx;
    logic [ERROR_BITS-1:0]   r_best;
    logic [CNT_W-1:0]        r_rem;
    logic [SUM_W-1:0]        r_quo;
    logic [DCNT_W-1:0]       r_dcnt;
    logic                    r_ovalid;

    logic                    w_cfg_wr;
    logic [2:0]              w_reg;
    logic [ERROR_BITS-1:0]   w_rdata;
    logic [ADDR_W-1:0]       w_raddr, w_waddr;
    logic [ERROR_BITS-1:0]   w_wdata;
    logic                    w_we;
    logic                    w_match;
    logic [TERM_W-1:0]       w_term;
    logic [CNT_W:0]          w_shift, w_diff;
    logic                    w_stop;
    logic [CNT_W-1:0]        w_last;

    assign w_cfg_wr = psel && penable && pwrite;
    assign w_reg    = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_mode    <= TM_NEVER;
            r_norm_kind    <= NK_MAX;
            r_direction    <= 1'b0;
            r_update_limit <= '0;
            r_error_level  <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg)
                REG_TERM_MODE:    r_term_mode    <= pwdata[1:0];
                REG_NORM_KIND:    r_norm_kind    <= pwdata[1:0];
                REG_DIRECTION:    r_direction    <= pwdata[0];
                REG_UPDATE_LIMIT: r_update_limit <= pwdata[15:0];
                REG_ERROR_LEVEL:  r_error_level  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_TERM_MODE:    prdata = {30'd0, r_term_mode};
            REG_NORM_KIND:    prdata = {30'd0, r_norm_kind};
            REG_DIRECTION:    prdata = {31'd0, r_direction};
            REG_UPDATE_LIMIT: prdata = {16'd0, r_update_limit};
            REG_ERROR_LEVEL:  prdata = r_error_level;
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        case (r_norm_kind)
            NK_MEAN: w_term = TERM_W'(i_error_value);
            NK_SQR:  w_term = i_error_value * i_error_value;
            default: w_term = '0;
        endcase
    end

    assign w_last  = r_count - CNT_W'(1);
    assign w_raddr = i_cmd.move_rd ? w_last[ADDR_W-1:0] : r_idx[ADDR_W-1:0];
    assign w_we    = i_cmd.add_commit || i_cmd.move_wr;
    assign w_waddr = i_cmd.move_wr ? r_hit_idx : r_count[ADDR_W-1:0];
    assign w_wdata = i_cmd.move_wr ? w_rdata : r_val;
    assign w_match = r_pend && (w_rdata == r_val);

    rent_ram #(.WIDTH(ERROR_BITS), .DEPTH(MAX_ELEMENTS)) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_agg    <= '0;
            r_upd    <= '1;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.add_commit) begin
                r_count <= r_count + CNT_W'(1);
                r_sum   <= r_sum + SUM_W'(r_term);
            end
            if (i_cmd.move_wr) begin
                r_count <= w_last;
                r_sum   <= r_sum - SUM_W'(r_term);
            end
            if (i_cmd.agg_zero) begin
                r_agg <= '0;
            end
            if (i_cmd.agg_div) begin
                r_agg <= r_quo[AGG_W-1:0];
            end
            if (i_cmd.agg_max) begin
                r_agg <= AGG_W'(r_best);
            end
            if (i_cmd.upd_inc && (r_upd != UPD_W'(UPD_MAX))) begin
                r_upd <= r_upd + UPD_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_pend <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_pend <= (r_idx < r_count);
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= i_func;
            r_val    <= i_error_value;
            r_term   <= w_term;
            r_status <= STATUS_OK;
        end
        if (i_cmd.st_full) begin
            r_status <= STATUS_FULL;
        end
        if (i_cmd.st_absent) begin
            r_status <= STATUS_ABSENT;
        end
        if (i_cmd.scan_start) begin
            r_idx  <= '0;
            r_best <= '0;
        end else begin
            if (i_cmd.scan_step && (r_idx < r_count)) begin
                r_pidx <= r_idx[ADDR_W-1:0];
                r_idx  <= r_idx + CNT_W'(1);
            end
            if (r_pend && (w_rdata > r_best)) begin
                r_best <= w_rdata;
            end
        end
        if (w_match) begin
            r_hit_idx <= r_pidx;
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_quo  <= r_sum;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            if (!w_diff[CNT_W]) begin
                r_rem <= w_diff[CNT_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[CNT_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
    end

    always_comb begin
        case (r_term_mode)
            TM_COUNT: w_stop = (r_upd >= $signed({1'b0, r_update_limit}));
            TM_LEVEL: w_stop = r_direction ? (r_agg >= r_error_level)
                                           : (r_agg <= r_error_level);
            default:  w_stop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_total_error   <= r_agg;
            o_element_count <= ELEM_W'(r_count);
            o_updates_done  <= r_upd;
            o_terminate     <= w_stop;
            o_status        <= r_status;
        end
    end

    assign o_valid = r_ovalid;

    always_comb begin
        o_stat           = '0;
        o_stat.is_add    = (r_func == FUNC_ADD) && (r_term_mode == TM_LEVEL);
        o_stat.is_rem    = (r_func == FUNC_REM) && (r_term_mode == TM_LEVEL);
        o_stat.is_upd    = (r_func == FUNC_UPD) && (r_term_mode == TM_COUNT);
        o_stat.full      = (r_count >= CNT_W'(MAX_ELEMENTS));
        o_stat.cnt_zero  = (r_count == '0);
        o_stat.mean_norm = (r_norm_kind == NK_MEAN) || (r_norm_kind == NK_SQR);
        o_stat.scan_done = !r_pend && (r_idx >= r_count);
        o_stat.hit       = w_match;
        o_stat.div_done  = (r_dcnt == DCNT_W'(DIV_STEPS));
        o_stat.out_free  = !r_ovalid || i_ready;
    end
endmodule
`default_nettype wire

// ===== design/running_error_norm_tracker.sv =====
// Top level of the running error norm tracker
// Update, full and no-op requests finish without a recompute; an add under a mean or square norm
// runs the divider, an add under the max norm scans the table; a removal first searches the table
// and moves the last entry into the gap, an absent removal ends after the search; output stalls hold all.
// Throughput: one request at a time; the single read port of the value
// table sets the search and scan length, the bit-serial divider the mean path.
// Reset: synchronous, active low; count, sum, aggregate clear, updates go to -1.
`default_nettype none
module running_error_norm_tracker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [1:0]                       i_func,
    input  wire logic [rent_pkg::ERROR_BITS-1:0]  i_error_value,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [rent_pkg::AGG_W-1:0]            o_total_error,
    output logic [rent_pkg::ELEM_W-1:0]           o_element_count,
    output logic signed [rent_pkg::UPD_W-1:0]     o_updates_done,
    output logic                                  o_terminate,
    output logic [1:0]                            o_status,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rent_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import rent_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign pready = 1'b1;

    rent_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_stat (w_stat),
        .o_cmd  (w_cmd)
    );

    rent_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_func         (i_func),
        .i_error_value  (i_error_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_total_error  (o_total_error),
        .o_element_count(o_element_count),
        .o_updates_done (o_updates_done),
        .o_terminate    (o_terminate),
        .o_status       (o_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata)
    );
endmodule
`default_nettype wire

// ===== design/rent_checker.sv =====
// Port-level assertion checker for the running error norm tracker, with its bind
`default_nettype none
`include "running_error_norm_tracker_assert.svh"
module rent_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             o_valid,
    input  wire logic                             i_ready,
    input  wire logic [rent_pkg::AGG_W-1:0]       o_total_error,
    input  wire logic [rent_pkg::ELEM_W-1:0]      o_element_count,
    input  wire logic [1:0]                       o_status
);
    import rent_pkg::*;

    `RENT_ASSERT_NXT(a_hold, o_valid && !i_ready, o_valid, "result dropped while stalled")
    `RENT_ASSERT_IMP(a_full, o_valid && (o_status == STATUS_FULL), o_element_count == ELEM_W'(MAX_ELEMENTS), "full without full table")
    `RENT_ASSERT_IMP(a_empty, o_valid && (o_element_count == '0), o_total_error == '0, "nonzero error on empty set")
    `RENT_ASSERT_IMP(a_cap, o_valid, o_element_count <= ELEM_W'(MAX_ELEMENTS), "count beyond table size")
endmodule

bind running_error_norm_tracker rent_checker u_rent_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_total_error  (o_total_error),
    .o_element_count(o_element_count),
    .o_status       (o_status)
);
`default_nettype wire
